@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker of the moving average filter.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/maf_pkg.sv @@
// Package of the moving average filter: fixed widths, request codes, FSM state
// type and the control struct of the serial arithmetic unit. Depends on nothing.
package maf_pkg;

	localparam int WL_BITS   = 7;
	localparam int FRAC_BITS = 8;

	localparam logic [WL_BITS-1:0] WL_RESET = 7'd64;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_REFILL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_ALU,
		ST_DIV_GO,
		ST_DIV,
		ST_OUT,
		ST_WALK
	} maf_state_t;

	typedef struct packed {
		logic start;
		logic refill;
	} alu_ctrl_t;

endpackage

@@ hw/rtl/maf_ring.sv @@
// Sample ring of the moving average filter: one write port and one registered
// read port. Depends on nothing.
module maf_ring #(
	parameter int DEPTH    = 64,
	parameter int WIDTH    = 16,
	parameter int PTR_BITS = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [PTR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                re,
	input  logic [PTR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/maf_serial_alu.sv @@
// Bit-serial running sum unit: adds new minus old sample, or forms the refill
// sum as value times window length, one bit per cycle. Depends on maf_pkg.
module maf_serial_alu
	import maf_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int SUM_BITS    = 23
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  alu_ctrl_t              ctrl,
	input  logic [SAMPLE_BITS-1:0] new_sample,
	input  logic [SAMPLE_BITS-1:0] old_sample,
	input  logic [WL_BITS-1:0]     win,
	output logic [SUM_BITS-1:0]    sum,
	output logic                   done
);

	localparam int ACC_W = WL_BITS + 1;
	localparam int CNT_W = $clog2(SUM_BITS);
	localparam int EXT_W = SUM_BITS - SAMPLE_BITS;

	logic [SUM_BITS-1:0] sum_q;
	logic [SUM_BITS-1:0] a_q;
	logic [SUM_BITS-1:0] o_q;
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                refill_q;
	logic [ACC_W-1:0]    t;
	logic                last;

	always_comb begin
		if (refill_q) begin
			t = (a_q[0] ? {1'b0, win} : '0) + acc_q;
		end else begin
			t = ACC_W'(sum_q[0]) + ACC_W'(a_q[0]) + ACC_W'(o_q[0]) + acc_q;
		end
	end

	assign last = busy_q && (cnt_q == CNT_W'(SUM_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			refill_q <= 1'b0;
		end else if (ctrl.start) begin
			busy_q   <= 1'b1;
			cnt_q    <= '0;
			refill_q <= ctrl.refill;
		end else if (busy_q) begin
			sum_q <= {t[0], sum_q[SUM_BITS-1:1]};
			cnt_q <= cnt_q + CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q   <= {{EXT_W{new_sample[SAMPLE_BITS-1]}}, new_sample};
			o_q   <= ~{{EXT_W{old_sample[SAMPLE_BITS-1]}}, old_sample};
			acc_q <= ctrl.refill ? '0 : ACC_W'(1);
		end else if (busy_q) begin
			a_q   <= {1'b0, a_q[SUM_BITS-1:1]};
			o_q   <= {1'b0, o_q[SUM_BITS-1:1]};
			acc_q <= {1'b0, t[ACC_W-1:1]};
		end
	end

	assign sum  = sum_q;
	assign done = last;

endmodule

@@ hw/rtl/maf_serial_div.sv @@
// Radix-2 restoring divider: running sum times 256 over the window length,
// truncated toward zero and saturated to the mean width. Depends on maf_pkg.
module maf_serial_div
	import maf_pkg::*;
#(
	parameter int SUM_BITS  = 23,
	parameter int MEAN_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_BITS-1:0]  sum,
	input  logic [WL_BITS-1:0]   win,
	output logic [MEAN_BITS-1:0] mean,
	output logic                 done
);

	localparam int Q_W   = SUM_BITS + FRAC_BITS;
	localparam int CNT_W = $clog2(Q_W);

	logic [Q_W-1:0]       dvd_q;
	logic [Q_W-1:0]       q_q;
	logic [WL_BITS-1:0]   rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic                 neg_q;
	logic [MEAN_BITS-1:0] mean_q;
	logic [SUM_BITS-1:0]  mag;
	logic [WL_BITS:0]     rs;
	logic [WL_BITS:0]     rs_sub;
	logic                 ge;
	logic                 ovf;
	logic [MEAN_BITS-1:0] sat;

	assign mag    = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;
	assign rs     = {rem_q, dvd_q[Q_W-1]};
	assign rs_sub = rs - {1'b0, win};
	assign ge     = (rs >= {1'b0, win});
	assign ovf    = |q_q[Q_W-1:MEAN_BITS-1];

	always_comb begin
		if (neg_q) begin
			sat = ovf ? {1'b1, {(MEAN_BITS-1){1'b0}}} :
				(~q_q[MEAN_BITS-1:0] + MEAN_BITS'(1));
		end else begin
			sat = ovf ? {1'b0, {(MEAN_BITS-1){1'b1}}} : q_q[MEAN_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, {FRAC_BITS{1'b0}}};
			q_q   <= '0;
			rem_q <= '0;
			neg_q <= sum[SUM_BITS-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[Q_W-2:0], 1'b0};
			q_q   <= {q_q[Q_W-2:0], ge};
			rem_q <= ge ? rs_sub[WL_BITS-1:0] : rs[WL_BITS-1:0];
		end
		if (fin_q) begin
			mean_q <= sat;
		end
	end

	assign mean = mean_q;
	assign done = done_q;

endmodule

@@ hw/rtl/moving_average_filter.sv @@
// Boxcar moving average over the most recent window_length samples.
// Input channel: in_valid/in_stall carry req_type and sample_value. A sample
// transaction replaces the oldest ring entry; a refill transaction writes the
// value into every entry. Each input transaction gives one output transaction
// on out_valid/out_stall carrying mean_value (8 fractional bits, truncated
// toward zero, saturated). window_length is written through cfg_valid/cfg_ready,
// always ready; write it only while idle and follow it with a refill.
// One transaction is worked on at a time. After a sample transaction is taken,
// the update state starts the ALU and writes the sample into the ring, the
// running sum is formed in one bit-serial pass, a state starts the radix-2
// divider, which gives one quotient bit per cycle, its finish and done registers
// settle the mean, and the output register is loaded once it is free.
// The next input transaction is taken at the earliest in the idle state after
// that load. A refill walks every ring entry through its single write port.
// After reset a clearing pass over all MAX_WINDOW entries zeroes the ring, with
// in_stall high; configuration writes are still taken. A result waits in the
// output register while out_stall is high; a new input transaction is taken
// meanwhile, and its result waits until the register is free.
module moving_average_filter
	import maf_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [SAMPLE_BITS-1:0]         sample_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [SAMPLE_BITS+FRAC_BITS-1:0] mean_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [WL_BITS-1:0]             window_length
);

	localparam int PTR_BITS  = $clog2(MAX_WINDOW);
	localparam int SUM_BITS  = SAMPLE_BITS + WL_BITS;
	localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int CMP_W     = (PTR_BITS + 1 > WL_BITS) ? PTR_BITS + 1 : WL_BITS;

	maf_state_t state_q, state_d;

	logic [WL_BITS-1:0]     wl_q;
	logic [WL_BITS-1:0]     win;
	logic                   req_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [PTR_BITS-1:0]    ptr_q;
	logic [PTR_BITS-1:0]    ptr_eff;
	logic [PTR_BITS-1:0]    ptr_next;
	logic [CMP_W-1:0]       p_inc;
	logic [PTR_BITS-1:0]    idx_q;
	logic                   out_valid_q;
	logic [MEAN_BITS-1:0]   mean_out_q;

	logic                   in_accept;
	logic                   mem_we;
	logic [PTR_BITS-1:0]    mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic                   mem_re;
	logic [SAMPLE_BITS-1:0] mem_rdata;
	logic                   walk_step;
	logic                   walk_last;
	logic                   ptr_adv;
	alu_ctrl_t              alu_ctrl;
	logic [SUM_BITS-1:0]    alu_sum;
	logic                   alu_done;
	logic                   div_start;
	logic [MEAN_BITS-1:0]   div_mean;
	logic                   div_done;
	logic                   out_load;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		if (wl_q == '0) begin
			win = WL_BITS'(1);
		end else if (int'(wl_q) > MAX_WINDOW) begin
			win = WL_BITS'(MAX_WINDOW);
		end else begin
			win = wl_q;
		end
	end

	assign ptr_eff   = (int'(ptr_q) >= MAX_WINDOW) ? '0 : ptr_q;
	assign p_inc     = CMP_W'(ptr_eff) + CMP_W'(1);
	assign ptr_next  = (p_inc >= CMP_W'(win)) ? '0 : p_inc[PTR_BITS-1:0];
	assign walk_last = (idx_q == PTR_BITS'(MAX_WINDOW - 1));

	always_comb begin
		state_d         = state_q;
		in_stall        = 1'b1;
		mem_we          = 1'b0;
		mem_waddr       = idx_q;
		mem_wdata       = sample_q;
		mem_re          = 1'b0;
		walk_step       = 1'b0;
		ptr_adv         = 1'b0;
		alu_ctrl.start  = 1'b0;
		alu_ctrl.refill = (req_q == REQ_REFILL);
		div_start       = 1'b0;
		out_load        = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				walk_step = 1'b1;
				if (walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				mem_re   = in_valid;
				if (in_valid) begin
					state_d = (req_type == REQ_REFILL) ? ST_WALK : ST_UPD;
				end
			end
			ST_WALK: begin
				mem_we    = 1'b1;
				walk_step = 1'b1;
				if (walk_last) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				alu_ctrl.start = 1'b1;
				if (req_q == REQ_SAMPLE) begin
					mem_we    = 1'b1;
					mem_waddr = ptr_eff;
					ptr_adv   = 1'b1;
				end
				state_d = ST_ALU;
			end
			ST_ALU: begin
				if (alu_done) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= WL_RESET;
			ptr_q       <= '0;
			idx_q       <= '0;
			req_q       <= REQ_SAMPLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				wl_q <= window_length;
			end
			if (in_accept) begin
				req_q <= req_type;
			end
			if (walk_step) begin
				idx_q <= walk_last ? '0 : idx_q + PTR_BITS'(1);
			end
			if (ptr_adv) begin
				ptr_q <= ptr_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= sample_value;
		end
		if (out_load) begin
			mean_out_q <= div_mean;
		end
	end

	maf_ring #(
		.DEPTH   (MAX_WINDOW),
		.WIDTH   (SAMPLE_BITS),
		.PTR_BITS(PTR_BITS)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(ptr_eff),
		.rdata(mem_rdata)
	);

	maf_serial_alu #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (alu_ctrl),
		.new_sample(sample_q),
		.old_sample(mem_rdata),
		.win       (win),
		.sum       (alu_sum),
		.done      (alu_done)
	);

	maf_serial_div #(
		.SUM_BITS (SUM_BITS),
		.MEAN_BITS(MEAN_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.sum   (alu_sum),
		.win   (win),
		.mean  (div_mean),
		.done  (div_done)
	);

	assign out_valid  = out_valid_q;
	assign mean_value = mean_out_q;

endmodule

@@ hw/rtl/maf_checker.sv @@
// Port-level checker of the moving average filter, bound to the top level.
// Depends on maf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module maf_checker
	import maf_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [SAMPLE_BITS+FRAC_BITS-1:0] mean_value
);

	// The block works on one transaction at a time, so it stalls after taking one.
	`AST_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// A new result is only produced while an input transaction is in progress.
	`AST_IMPLY(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall))
	`AST_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)
	`AST_NEXT(a_hold_mean, clk, arst_n, out_valid && out_stall, $stable(mean_value))

endmodule

bind moving_average_filter maf_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_maf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.mean_value(mean_value)
);
